### sv/bicd_pkg.sv
// Shared types, constants and the quarter-wave sine table generator for the I/Q correlator.
package bicd_pkg;

    // Default data widths handed to the top level.
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int ACC_BITS_DEFAULT    = 48;

    // Quarter-wave table depth; entries run from 0 to SINE_TABLE_DEPTH inclusive.
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int ROM_ADDR_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_IDX_BITS     = ROM_ADDR_BITS + 1;

    // Width of the Q1.15 sine and cosine values.
    localparam int TRIG_BITS = 16;

    // Pi/2 in unsigned Q2.30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DEMOD_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLES_PER_CYCLE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CYCLES_PER_SYMBOL = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET      = 3'd4;

    // Register reset values.
    localparam logic        DEMOD_ENABLE_RESET      = 1'b0;
    localparam logic [7:0]  SAMPLES_PER_CYCLE_RESET = 8'd49;
    localparam logic [7:0]  CYCLES_PER_SYMBOL_RESET = 8'd10;
    localparam logic [15:0] PHASE_STEP_RESET        = 16'd1337;
    localparam logic [15:0] PHASE_OFFSET_RESET      = 16'd0;

    // Quarter turn of the 16-bit carrier phase.
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    typedef struct packed {
        logic        demod_enable;
        logic [7:0]  samples_per_cycle;
        logic [7:0]  cycles_per_symbol;
        logic [15:0] phase_step;
        logic [15:0] phase_offset;
    } cfg_t;

    // Carrier values and the end-of-window mark that travel with one sample.
    typedef struct packed {
        logic signed [TRIG_BITS-1:0] sine;
        logic signed [TRIG_BITS-1:0] cosine;
        logic                        last;
    } tap_t;

    // One table entry: sin(k * (pi/2) / SINE_TABLE_DEPTH) by an 11th-order Taylor
    // series in Q2.30 with truncated terms, rounded half-up to Q1.15 and saturated.
    function automatic logic [TRIG_BITS-2:0] rom_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        if (sum <= 64'sd0)
        begin
            return '0;
        end
        rounded = (unsigned'(sum) + 64'd16384) >> 15;
        if (rounded > 64'd32767)
        begin
            return '1;
        end
        return rounded[TRIG_BITS-2:0];
    endfunction

endpackage

### sv/bicd_cfg_regs.sv
// Configuration register file of the I/Q correlator.
module bicd_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bicd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bicd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output bicd_pkg::cfg_t                      cfg
);

    bicd_pkg::cfg_t cfg_reg;
    bicd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                bicd_pkg::REG_DEMOD_ENABLE:      cfg_next.demod_enable      = cfg_data[0];
                bicd_pkg::REG_SAMPLES_PER_CYCLE: cfg_next.samples_per_cycle = cfg_data[7:0];
                bicd_pkg::REG_CYCLES_PER_SYMBOL: cfg_next.cycles_per_symbol = cfg_data[7:0];
                bicd_pkg::REG_PHASE_STEP:        cfg_next.phase_step        = cfg_data[15:0];
                bicd_pkg::REG_PHASE_OFFSET:      cfg_next.phase_offset      = cfg_data[15:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.demod_enable      <= bicd_pkg::DEMOD_ENABLE_RESET;
            cfg_reg.samples_per_cycle <= bicd_pkg::SAMPLES_PER_CYCLE_RESET;
            cfg_reg.cycles_per_symbol <= bicd_pkg::CYCLES_PER_SYMBOL_RESET;
            cfg_reg.phase_step        <= bicd_pkg::PHASE_STEP_RESET;
            cfg_reg.phase_offset      <= bicd_pkg::PHASE_OFFSET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/bicd_sine_lut.sv
// Quarter-wave table lookup giving the sine and cosine of a 16-bit phase.
module bicd_sine_lut (
    input  logic [15:0]                                phase,
    output logic signed [bicd_pkg::TRIG_BITS-1:0]      sine,
    output logic signed [bicd_pkg::TRIG_BITS-1:0]      cosine
);

    localparam int Depth    = bicd_pkg::SINE_TABLE_DEPTH;
    localparam int AddrBits = bicd_pkg::ROM_ADDR_BITS;
    localparam int IdxBits  = bicd_pkg::ROM_IDX_BITS;
    localparam int ScaleW   = 14 + IdxBits;
    localparam int EntryW   = bicd_pkg::TRIG_BITS - 1;
    localparam logic [EntryW-1:0] TopEntry = bicd_pkg::rom_entry(Depth);

    logic [EntryW-1:0] rom [Depth];

    for (genvar k = 0; k < Depth; k++)
    begin : g_rom
        localparam logic [EntryW-1:0] Entry = bicd_pkg::rom_entry(k);
        assign rom[k] = Entry;
    end

    logic [15:0] cos_phase;

    function automatic logic signed [bicd_pkg::TRIG_BITS-1:0] lookup(
        input logic [15:0]       ph,
        input logic [EntryW-1:0] tbl [Depth]
    );
        logic [ScaleW-1:0]  scaled;
        logic [IdxBits-1:0] idx;
        logic [IdxBits-1:0] addr;
        logic [EntryW-1:0]  mag;
        scaled = ScaleW'(ph[13:0]) * ScaleW'(Depth);
        idx    = scaled[ScaleW-1:14];
        addr   = ph[14] ? (IdxBits'(Depth) - idx) : idx;
        mag    = (addr == IdxBits'(Depth)) ? TopEntry : tbl[addr[AddrBits-1:0]];
        return ph[15] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    endfunction

    assign cos_phase = phase + bicd_pkg::QUARTER_TURN;
    assign sine      = lookup(phase, rom);
    assign cosine    = lookup(cos_phase, rom);

endmodule

### sv/bicd_carrier.sv
// Carrier sequencer: period and window counters, phase accumulator and the input register.
module bicd_carrier #(
    parameter int SAMPLE_BITS = bicd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bicd_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          s1_valid,
    input  logic                          s1_ready,
    output logic signed [SAMPLE_BITS-1:0] s1_sample,
    output bicd_pkg::tap_t                s1_tap
);

    logic [7:0]  sample_in_cycle_reg;
    logic [7:0]  sample_in_cycle_next;
    logic [7:0]  cycle_in_symbol_reg;
    logic [7:0]  cycle_in_symbol_next;
    logic [15:0] carrier_phase_reg;
    logic [15:0] carrier_phase_next;
    logic        s1_valid_reg;
    logic        s1_valid_next;

    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    bicd_pkg::tap_t                s1_tap_reg;

    logic        take;
    logic [7:0]  sample_inc;
    logic [7:0]  cycle_inc;
    logic        period_end;
    logic        window_end;
    logic signed [bicd_pkg::TRIG_BITS-1:0] sine;
    logic signed [bicd_pkg::TRIG_BITS-1:0] cosine;

    bicd_sine_lut u_lut (
        .phase  (carrier_phase_reg),
        .sine   (sine),
        .cosine (cosine)
    );

    assign in_ready = !s1_valid_reg || s1_ready;
    assign take     = in_valid && in_ready && cfg.demod_enable;

    always_comb
    begin
        sample_inc           = sample_in_cycle_reg + 8'd1;
        cycle_inc            = cycle_in_symbol_reg + 8'd1;
        period_end           = sample_inc >= cfg.samples_per_cycle;
        window_end           = period_end && (cycle_inc >= cfg.cycles_per_symbol);
        sample_in_cycle_next = sample_in_cycle_reg;
        cycle_in_symbol_next = cycle_in_symbol_reg;
        carrier_phase_next   = carrier_phase_reg;
        if (take)
        begin
            if (period_end)
            begin
                sample_in_cycle_next = 8'd0;
                carrier_phase_next   = cfg.phase_offset;
                cycle_in_symbol_next = window_end ? 8'd0 : cycle_inc;
            end
            else
            begin
                sample_in_cycle_next = sample_inc;
                carrier_phase_next   = carrier_phase_reg + cfg.phase_step;
            end
        end
    end

    always_comb
    begin
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_in_cycle_reg <= 8'd0;
            cycle_in_symbol_reg <= 8'd0;
            carrier_phase_reg   <= bicd_pkg::PHASE_OFFSET_RESET;
            s1_valid_reg        <= 1'b0;
        end
        else
        begin
            sample_in_cycle_reg <= sample_in_cycle_next;
            cycle_in_symbol_reg <= cycle_in_symbol_next;
            carrier_phase_reg   <= carrier_phase_next;
            s1_valid_reg        <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_sample_reg     <= sample;
            s1_tap_reg.sine   <= sine;
            s1_tap_reg.cosine <= cosine;
            s1_tap_reg.last   <= window_end;
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_sample = s1_sample_reg;
    assign s1_tap    = s1_tap_reg;

endmodule

### sv/bicd_mac.sv
// Multiply stage, integrate-and-dump accumulators and the result register.
module bicd_mac #(
    parameter int SAMPLE_BITS = bicd_pkg::SAMPLE_BITS_DEFAULT,
    parameter int ACC_BITS    = bicd_pkg::ACC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    output logic                          s1_ready,
    input  logic signed [SAMPLE_BITS-1:0] s1_sample,
    input  bicd_pkg::tap_t                s1_tap,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ACC_BITS-1:0]    i_sum,
    output logic signed [ACC_BITS-1:0]    q_sum
);

    localparam int ProdBits = SAMPLE_BITS + bicd_pkg::TRIG_BITS;
    localparam int ExtBits  = (ProdBits > ACC_BITS) ? ProdBits : ACC_BITS;

    logic                       s2_valid_reg;
    logic                       s2_valid_next;
    logic signed [ProdBits-1:0] prod_i_reg;
    logic signed [ProdBits-1:0] prod_q_reg;
    logic                       last2_reg;

    logic signed [ACC_BITS-1:0] acc_i_reg;
    logic signed [ACC_BITS-1:0] acc_i_next;
    logic signed [ACC_BITS-1:0] acc_q_reg;
    logic signed [ACC_BITS-1:0] acc_q_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [ACC_BITS-1:0] i_sum_reg;
    logic signed [ACC_BITS-1:0] q_sum_reg;

    logic                       adv3;
    logic                       load2;
    logic signed [ExtBits-1:0]  ext_i;
    logic signed [ExtBits-1:0]  ext_q;
    logic signed [ACC_BITS-1:0] total_i;
    logic signed [ACC_BITS-1:0] total_q;

    // A product moves on unless it closes a window while the result register is still held.
    assign adv3     = s2_valid_reg && !(last2_reg && out_valid_reg && !out_ready);
    assign s1_ready = !s2_valid_reg || adv3;
    assign load2    = s1_valid && s1_ready;

    assign ext_i   = ExtBits'(prod_i_reg);
    assign ext_q   = ExtBits'(prod_q_reg);
    assign total_i = acc_i_reg + ext_i[ACC_BITS-1:0];
    assign total_q = acc_q_reg + ext_q[ACC_BITS-1:0];

    always_comb
    begin
        s2_valid_next  = load2 ? 1'b1 : (adv3 ? 1'b0 : s2_valid_reg);
        acc_i_next     = acc_i_reg;
        acc_q_next     = acc_q_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (adv3)
        begin
            if (last2_reg)
            begin
                acc_i_next     = '0;
                acc_q_next     = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_i_next = total_i;
                acc_q_next = total_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            acc_i_reg     <= '0;
            acc_q_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            acc_i_reg     <= acc_i_next;
            acc_q_reg     <= acc_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            prod_i_reg <= s1_sample * s1_tap.sine;
            prod_q_reg <= s1_sample * s1_tap.cosine;
            last2_reg  <= s1_tap.last;
        end
        if (adv3 && last2_reg)
        begin
            i_sum_reg <= total_i;
            q_sum_reg <= total_q;
        end
    end

    assign out_valid = out_valid_reg;
    assign i_sum     = i_sum_reg;
    assign q_sum     = q_sum_reg;

`ifndef ASSERT_OFF
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(adv3 && last2_reg))
        else $error("result register loaded without a window end");

    a_dump_clears: assert property (@(posedge clk) disable iff (!rst_n)
        adv3 && last2_reg |=> (acc_i_reg == '0) && (acc_q_reg == '0))
        else $error("accumulators not cleared after a window end");

    a_product_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !adv3 |=> s2_valid_reg && $stable(prod_i_reg)
            && $stable(prod_q_reg))
        else $error("stalled product lost or changed");
`endif

endmodule

### sv/bpsk_iq_correlator_demodulator_unit.sv
// Top level of the BPSK integrate-and-dump I/Q correlator.
//
// Usage: audio samples enter on the in_valid / in_ready channel, one per
// transfer. While demod_enable is set, each sample is multiplied by the sine
// and cosine of a local carrier whose phase restarts at phase_offset at the
// start of every carrier period of samples_per_cycle samples. The products
// are summed over cycles_per_symbol carrier periods, and at the end of that
// window one transfer on out_valid / out_ready carries i_sum and q_sum, after
// which both sums restart from zero. While disabled, samples are taken and
// dropped. Configuration is written through cfg_wr_en / cfg_index / cfg_data
// and should change only while the block is idle.
// Throughput is one sample per clock cycle while no window end waits on a held
// result. A window's final sample passes through the input register, the product
// register, then the result register fed by the accumulator adder.
// When the receiver stalls, samples keep flowing into the accumulators; only a
// window end waiting on a held result stops the pipeline, and backpressure
// then reaches in_ready. Reset clears the counters, the accumulators and all
// valid flags, and loads the register defaults.
module bpsk_iq_correlator_demodulator_unit #(
    parameter int SAMPLE_BITS = bicd_pkg::SAMPLE_BITS_DEFAULT,
    parameter int ACC_BITS    = bicd_pkg::ACC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bicd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bicd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ACC_BITS-1:0]          i_sum,
    output logic signed [ACC_BITS-1:0]          q_sum
);

    // Live register values shared by the sequencer.
    bicd_pkg::cfg_t cfg;

    // Input register contents handed to the multiply stage.
    logic                          s1_valid;
    logic                          s1_ready;
    logic signed [SAMPLE_BITS-1:0] s1_sample;
    bicd_pkg::tap_t                s1_tap;

    bicd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The sequencer looks up the carrier for the sample being taken and marks
    // the sample that closes a window.
    bicd_carrier #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_carrier (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_sample (s1_sample),
        .s1_tap    (s1_tap)
    );

    // Multiply, accumulate and dump into the result register.
    bicd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_sample (s1_sample),
        .s1_tap    (s1_tap),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .i_sum     (i_sum),
        .q_sum     (q_sum)
    );

endmodule
